[src/ifdr_pkg.sv]
// Shared types and constants for the indexed frame diff run core.
// No dependencies; imported by the core, the result queue and the testbench.
package ifdr_pkg;

  localparam int COORD_W     = 8;
  localparam int IDX_W       = 4;
  localparam int COLOR_W     = 16;
  localparam int PAL_DEPTH   = 16;
  localparam int OFIFO_DEPTH = 4;

  localparam logic [IDX_W-1:0] IDX_RESET     = 4'hF;
  localparam logic             OP_PAL_WRITE  = 1'b1;

  typedef struct packed {
    logic               first;
    logic               last;
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } result_t;

  // Up to two results per transaction; valid1 implies valid0.
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

[src/ifdr_ram.sv]
// Generic single-write, single-read RAM with registered read (old data on collision).
// No dependencies.
module ifdr_ram #(
  parameter int  DATA_W = 4,
  parameter int  DEPTH  = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/ifdr_out_fifo.sv]
// Small result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on ifdr_pkg.
module ifdr_out_fifo
  import ifdr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    space_ok,
  output logic    out_tvalid,
  input  logic    out_tready,
  output result_t out_item
);

  localparam int PTR_W = $clog2(OFIFO_DEPTH);
  localparam int CNT_W = $clog2(OFIFO_DEPTH + 1);

  result_t            mem_r [OFIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [1:0]         push_n;
  logic               pop;

  assign out_tvalid = (count_r != '0);
  assign out_item   = mem_r[rd_ptr_r];
  assign space_ok   = (count_r <= CNT_W'(OFIFO_DEPTH - 2));
  assign pop        = out_tvalid && out_tready;
  assign push_n     = {1'b0, push.valid0} + {1'b0, push.valid1};

  always_comb begin
    count_nxt = count_r + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.valid1) begin
      mem_r[wr_ptr_r + PTR_W'(1)] <= push.r1;
    end
  end

endmodule

[src/indexed_frame_diff_runs_core.sv]
// Top level: frame diff against stored indices, palette lookup, run marking.
// Depends on ifdr_pkg, ifdr_ram, ifdr_out_fifo.
//
//  channel | dir | handshake              | contents
//  in_     | in  | in_tvalid / in_tready   | tdata, tlast = row_end, tuser = opcode
//  out_    | out | out_tvalid / out_tready | tdata, tlast = run_last, tuser = run_first
//  cfg_    | in  | cfg_valid / cfg_ready   | cfg_data = full_redraw
//
// One transaction per cycle unless stalled; results go via s1 registers and the queue.
// The stored-frame RAM read is issued at acceptance and compared in the next cycle.
// After reset a clearing pass writes index 15 to all FRAME_WIDTH*FRAME_HEIGHT cells
// of the stored frame (65536 by default); in_tready stays low meanwhile.
// A stalled output backs up into a four-entry result queue, then into the input.
module indexed_frame_diff_runs_core
  import ifdr_pkg::*;
#(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] pixel_x, [15:8] pixel_y, [19:16] pixel_index, [23:20] palette_slot,
  // [39:24] palette_color
  input  logic [39:0] in_tdata,
  input  logic        in_tlast,
  // [0] opcode
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] out_x, [15:8] out_y, [31:16] color565
  output logic [31:0] out_tdata,
  output logic        out_tlast,
  // [0] run_first
  output logic        out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int CELLS  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = $clog2(CELLS);

  // input fields
  logic [COORD_W-1:0] in_x, in_y;
  logic [IDX_W-1:0]   in_idx, in_slot;
  logic [COLOR_W-1:0] in_pcolor;
  logic               in_inframe;
  logic [ADDR_W-1:0]  in_addr;
  logic               in_fire;

  assign in_x      = in_tdata[7:0];
  assign in_y      = in_tdata[15:8];
  assign in_idx    = in_tdata[19:16];
  assign in_slot   = in_tdata[23:20];
  assign in_pcolor = in_tdata[39:24];

  assign in_inframe = ({1'b0, in_x} < (COORD_W+1)'(FRAME_WIDTH)) &&
                      ({1'b0, in_y} < (COORD_W+1)'(FRAME_HEIGHT));
  assign in_addr    = in_inframe ?
                      ADDR_W'(ADDR_W'(in_y) * ADDR_W'(FRAME_WIDTH)) + ADDR_W'(in_x) : '0;

  // stage registers
  logic               s1_valid_r, s1_op_r, s1_last_r, s1_inframe_r;
  logic [COORD_W-1:0] s1_x_r, s1_y_r;
  logic [IDX_W-1:0]   s1_idx_r, s1_slot_r;
  logic [COLOR_W-1:0] s1_pcolor_r;
  logic [ADDR_W-1:0]  s1_addr_r;
  logic               s1_fire;

  // hold register
  logic               hold_valid_r, hold_first_r;
  logic [COORD_W-1:0] hold_x_r, hold_y_r;
  logic [COLOR_W-1:0] hold_color_r;

  logic               full_redraw_r;
  logic               clear_done_r;
  logic [ADDR_W-1:0]  clr_cnt_r;

  logic               fw_valid_r;
  logic [ADDR_W-1:0]  fw_addr_r;
  logic [IDX_W-1:0]   fw_data_r;

  logic [COLOR_W-1:0] palette_r [PAL_DEPTH];

  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
  logic [IDX_W-1:0]   ram_wr_data, ram_rd_data;

  logic               is_pixel, changed, continues, px_wr;
  logic [IDX_W-1:0]   stored_idx;
  logic [COLOR_W-1:0] cur_color;
  logic               hold_valid_nxt;

  push_t              push;
  logic               space_ok;
  result_t            out_item;

  assign cfg_ready = 1'b1;

  assign s1_fire   = s1_valid_r && space_ok;
  assign in_tready = clear_done_r && (!s1_valid_r || s1_fire);
  assign in_fire   = in_tvalid && in_tready;

  assign ram_rd_addr = in_fire ? in_addr : s1_addr_r;
  assign stored_idx  = (fw_valid_r && fw_addr_r == s1_addr_r) ? fw_data_r : ram_rd_data;
  assign cur_color   = palette_r[s1_idx_r];

  assign is_pixel  = s1_op_r != OP_PAL_WRITE;
  assign changed   = is_pixel && s1_inframe_r && (full_redraw_r || stored_idx != s1_idx_r);
  assign continues = hold_valid_r && (hold_y_r == s1_y_r) &&
                     ({1'b0, hold_x_r} + (COORD_W+1)'(1) == {1'b0, s1_x_r});
  assign px_wr     = s1_fire && changed;

  assign ram_wr_en   = !clear_done_r || px_wr;
  assign ram_wr_addr = clear_done_r ? s1_addr_r : clr_cnt_r;
  assign ram_wr_data = clear_done_r ? s1_idx_r : IDX_RESET;

  always_comb begin
    push           = '0;
    hold_valid_nxt = hold_valid_r;
    if (s1_fire && is_pixel) begin
      hold_valid_nxt = changed && !s1_last_r;
      if (hold_valid_r) begin
        push.valid0   = 1'b1;
        push.r0.x     = hold_x_r;
        push.r0.y     = hold_y_r;
        push.r0.color = hold_color_r;
        push.r0.first = hold_first_r;
        push.r0.last  = !(changed && continues);
      end
      if (changed && s1_last_r) begin
        if (hold_valid_r) begin
          push.valid1   = 1'b1;
          push.r1.x     = s1_x_r;
          push.r1.y     = s1_y_r;
          push.r1.color = cur_color;
          push.r1.first = !continues;
          push.r1.last  = 1'b1;
        end else begin
          push.valid0   = 1'b1;
          push.r0.x     = s1_x_r;
          push.r0.y     = s1_y_r;
          push.r0.color = cur_color;
          push.r0.first = 1'b1;
          push.r0.last  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      hold_valid_r  <= 1'b0;
      hold_x_r      <= '0;
      hold_y_r      <= '0;
      hold_color_r  <= '0;
      hold_first_r  <= 1'b0;
      full_redraw_r <= 1'b0;
      clear_done_r  <= 1'b0;
      clr_cnt_r     <= '0;
      fw_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      hold_valid_r <= hold_valid_nxt;
      if (s1_fire && changed && !s1_last_r) begin
        hold_x_r     <= s1_x_r;
        hold_y_r     <= s1_y_r;
        hold_color_r <= cur_color;
        hold_first_r <= !continues;
      end
      if (cfg_valid && cfg_ready) begin
        full_redraw_r <= cfg_data;
      end
      if (!clear_done_r) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(CELLS - 1)) begin
          clear_done_r <= 1'b1;
        end
      end
      fw_valid_r <= px_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r      <= in_tuser;
      s1_last_r    <= in_tlast;
      s1_inframe_r <= in_inframe;
      s1_x_r       <= in_x;
      s1_y_r       <= in_y;
      s1_idx_r     <= in_idx;
      s1_slot_r    <= in_slot;
      s1_pcolor_r  <= in_pcolor;
      s1_addr_r    <= in_addr;
    end
    if (px_wr) begin
      fw_addr_r <= s1_addr_r;
      fw_data_r <= s1_idx_r;
    end
    if (s1_fire && !is_pixel) begin
      palette_r[s1_slot_r] <= s1_pcolor_r;
    end
  end

  ifdr_ram #(
    .DATA_W (IDX_W),
    .DEPTH  (CELLS)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  ifdr_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .space_ok   (space_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_item   (out_item)
  );

  assign out_tdata = {out_item.color, out_item.y, out_item.x};
  assign out_tlast = out_item.last;
  assign out_tuser = out_item.first;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for indexed_frame_diff_runs_core: directed and random pixel streams
// against a behavioral predictor of the frame diff, palette lookup and run marking.
// Depends on ifdr_pkg and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ifdr_pkg::*;

  localparam int FRAME_W        = 256;
  localparam int FRAME_H        = 256;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 4 * FRAME_W * FRAME_H + 10000;

  localparam logic OP_PIXEL = 1'b0;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_data   = 1'b0;

  // predictor state
  logic [IDX_W-1:0]   shadow_frame [FRAME_W*FRAME_H];
  logic [COLOR_W-1:0] shadow_palette [PAL_DEPTH];
  logic               redraw_all = 1'b0;
  logic               held_valid = 1'b0;
  logic [7:0]         held_x     = '0;
  logic [7:0]         held_y     = '0;
  logic [15:0]        held_color = '0;
  logic               held_first = 1'b0;
  result_t            pending_pixels [$];

  int fail_count   = 0;
  int quiet_cycles = 0;
  int burst_left   = 0;

  ready_mode_t ready_mode = READY_ALWAYS;
  int          ready_left = 0;

  indexed_frame_diff_runs_core #(
    .FRAME_WIDTH (FRAME_W),
    .FRAME_HEIGHT(FRAME_H)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void emit_pixel(logic [7:0] x, logic [7:0] y, logic [15:0] color,
                                     logic first, logic last);
    result_t r;
    r.x     = x;
    r.y     = y;
    r.color = color;
    r.first = first;
    r.last  = last;
    pending_pixels.push_back(r);
  endfunction

  function automatic void diff_pixel(logic [7:0] x, logic [7:0] y, logic [3:0] idx,
                                     logic row_end);
    int   addr;
    logic changed;
    logic cont;
    logic [15:0] color;
    addr    = 0;
    changed = 1'b0;
    if (int'(x) < FRAME_W && int'(y) < FRAME_H) begin
      addr    = int'(y) * FRAME_W + int'(x);
      changed = redraw_all || shadow_frame[addr] != idx;
    end
    if (!changed) begin
      if (held_valid) begin
        emit_pixel(held_x, held_y, held_color, held_first, 1'b1);
        held_valid = 1'b0;
      end
    end else begin
      shadow_frame[addr] = idx;
      color = shadow_palette[idx];
      cont  = held_valid && held_y == y && int'(held_x) + 1 == int'(x);
      if (held_valid) begin
        emit_pixel(held_x, held_y, held_color, held_first, !cont);
        held_valid = 1'b0;
      end
      if (row_end) begin
        emit_pixel(x, y, color, !cont, 1'b1);
      end else begin
        held_valid = 1'b1;
        held_x     = x;
        held_y     = y;
        held_color = color;
        held_first = !cont;
      end
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // transaction monitor: result check, then prediction for accepted input
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen.x     = out_tdata[7:0];
        seen.y     = out_tdata[15:8];
        seen.color = out_tdata[31:16];
        seen.first = out_tuser;
        seen.last  = out_tlast;
        if (pending_pixels.size() == 0) begin
          $error("unexpected result x=%0d y=%0d color=0x%0h", seen.x, seen.y, seen.color);
          fail_count++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("out_x", want.x, seen.x);
          check_field("out_y", want.y, seen.y);
          check_field("color565", want.color, seen.color);
          check_field("run_first", want.first, seen.first);
          check_field("run_last", want.last, seen.last);
        end
      end
      if (cfg_valid && cfg_ready) redraw_all = cfg_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_PAL_WRITE) shadow_palette[in_tdata[23:20]] = in_tdata[39:24];
        else diff_pixel(in_tdata[7:0], in_tdata[15:8], in_tdata[19:16], in_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 2));
      ready_left = $urandom_range(16, 200);
    end
    ready_left--;
    case (ready_mode)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_COIN:   out_tready <= 1'($urandom_range(0, 1));
      default:      out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  task automatic send_item(logic op, logic [7:0] x, logic [7:0] y, logic [3:0] idx,
                           logic last, logic [3:0] slot, logic [15:0] color);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tdata  <= {color, slot, idx, y, x};
    in_tlast  <= last;
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_pixel(logic [7:0] x, logic [7:0] y, logic [3:0] idx, logic row_end);
    send_item(OP_PIXEL, x, y, idx, row_end, 4'($urandom), 16'($urandom));
  endtask

  task automatic send_palette(logic [3:0] slot, logic [15:0] color);
    send_item(OP_PAL_WRITE, 8'($urandom), 8'($urandom), 4'($urandom), 1'($urandom),
              slot, color);
  endtask

  // closes any held run with a row-end pixel that keeps its stored index,
  // then drains the results
  task automatic settle_block();
    int x;
    int y;
    x = $urandom_range(0, FRAME_W - 1);
    y = $urandom_range(0, FRAME_H - 1);
    send_pixel(8'(x), 8'(y), shadow_frame[y * FRAME_W + x], 1'b1);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_redraw(logic value);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_palette_load();
    logic [15:0] color;
    for (int s = 0; s < PAL_DEPTH; s++) begin
      case (s)
        0:       color = 16'h0000;
        5:       color = 16'h5555;
        10:      color = 16'hAAAA;
        15:      color = 16'hFFFF;
        default: color = 16'($urandom);
      endcase
      send_palette(4'(s), color);
    end
  endtask

  // stored frame starts at index 15 everywhere
  task automatic test_reset_frame();
    send_pixel(8'd0, 8'd0, 4'd15, 1'b0);
    send_pixel(8'd1, 8'd0, 4'd3, 1'b0);
    send_pixel(8'd2, 8'd0, 4'd15, 1'b0);
    send_pixel(8'd3, 8'd0, 4'd0, 1'b0);
    send_pixel(8'd4, 8'd0, 4'd1, 1'b1);
  endtask

  task automatic test_run_breaks();
    send_pixel(8'(FRAME_W - 3), 8'(FRAME_H - 1), 4'd7, 1'b0);
    send_pixel(8'(FRAME_W - 1), 8'(FRAME_H - 1), 4'd8, 1'b0);
    send_pixel(8'd0, 8'(FRAME_H - 1), 4'd2, 1'b0);
    send_pixel(8'(FRAME_W - 1), 8'd1, 4'd9, 1'b1);
    send_pixel(8'(FRAME_W - 1), 8'd1, 4'd9, 1'b1);
  endtask

  // held pixel keeps the color it was looked up with
  task automatic test_palette_under_hold();
    send_pixel(8'd10, 8'd5, 4'd6, 1'b0);
    send_palette(4'd6, ~shadow_palette[6]);
    send_pixel(8'd11, 8'd5, 4'd6, 1'b1);
  endtask

  task automatic test_frame_edge();
    send_pixel(8'd20, 8'd6, 4'd2, 1'b0);
    send_pixel(8'(FRAME_W - 1), 8'd6, 4'd3, 1'b0);
    send_pixel(8'd21, 8'(FRAME_H - 1), 4'd4, 1'b0);
    send_pixel(8'd255, 8'd255, 4'd15, 1'b1);
  endtask

  task automatic test_full_redraw();
    write_redraw(1'b1);
    send_pixel(8'd0, 8'd0, 4'd15, 1'b0);
    send_pixel(8'd1, 8'd0, 4'd3, 1'b0);
    send_pixel(8'd2, 8'd0, 4'd15, 1'b0);
    send_pixel(8'(FRAME_W - 1), 8'd0, 4'd0, 1'b0);
    send_pixel(8'd3, 8'd0, 4'd0, 1'b0);
    send_pixel(8'd4, 8'd0, 4'd1, 1'b1);
    write_redraw(1'b0);
  endtask

  task automatic test_random(int n_items, logic mode);
    int   sent;
    int   len;
    int   x0;
    int   y;
    int   x;
    logic broken;
    logic last;
    logic [3:0] idx;
    sent = 0;
    write_redraw(mode);
    while (sent < n_items) begin
      case ($urandom_range(0, 15))
        0: begin
          send_palette(4'($urandom), 16'($urandom));
          sent++;
        end
        1: begin
          send_pixel(8'($urandom), 8'($urandom), 4'($urandom), 1'($urandom));
          sent++;
        end
        default: begin
          len    = ($urandom_range(0, 15) == 0) ? $urandom_range(1, FRAME_W)
                                                : $urandom_range(1, 10);
          x0     = $urandom_range(0, FRAME_W - len);
          y      = $urandom_range(0, FRAME_H - 1);
          broken = ($urandom_range(0, 7) == 0);
          for (int i = 0; i < len; i++) begin
            if (broken && $urandom_range(0, 5) == 0) continue;
            x    = x0 + i;
            idx  = ($urandom_range(0, 2) == 0) ? shadow_frame[y * FRAME_W + x]
                                               : 4'($urandom);
            last = (i == len - 1) && !(broken && $urandom_range(0, 1) == 1);
            if ($urandom_range(0, 50) == 0) begin
              send_palette(4'($urandom), 16'($urandom));
              sent++;
            end
            send_pixel(8'(x), 8'(y), idx, last);
            sent++;
          end
        end
      endcase
    end
  endtask

  initial begin
    foreach (shadow_frame[i]) shadow_frame[i] = IDX_RESET;
    foreach (shadow_palette[i]) shadow_palette[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    write_redraw(1'b0);
    test_palette_load();
    test_reset_frame();
    test_run_breaks();
    test_palette_under_hold();
    test_frame_edge();
    test_full_redraw();
    test_random(800, 1'b0);
    test_random(500, 1'b1);
    test_random(700, 1'b0);
    settle_block();
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
